[design/ecgfc_pkg.sv]
// ecgfc_pkg: shared types, codes and the code map of the ecg fiducial cycle grouper
// no dependencies
`default_nettype none

package ecgfc_pkg;

  localparam int SAMPLE_W = 32;
  localparam int WIN_LEN  = 11;
  localparam int FILL_W   = $clog2(WIN_LEN + 1);
  localparam int IDX_W    = $clog2(WIN_LEN);
  localparam int OUT_PER_CYCLE = 13;
  localparam int STEP_W   = $clog2(OUT_PER_CYCLE);
  localparam int STEP_LAST = OUT_PER_CYCLE - 1;
  localparam int PEAKQ_STEP = 5;
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [2:0] WAVE_UNK   = 3'd0;
  localparam logic [2:0] WAVE_P     = 3'd1;
  localparam logic [2:0] WAVE_QRS   = 3'd2;
  localparam logic [2:0] WAVE_T     = 3'd3;
  localparam logic [2:0] WAVE_U     = 3'd4;
  localparam logic [2:0] WAVE_CYCLE = 3'd5;

  localparam logic [3:0] KIND_UNK    = 4'd0;
  localparam logic [3:0] KIND_START  = 4'd1;
  localparam logic [3:0] KIND_END    = 4'd2;
  localparam logic [3:0] KIND_PEAK_P = 4'd3;
  localparam logic [3:0] KIND_PEAK_Q = 4'd4;
  localparam logic [3:0] KIND_PEAK_R = 4'd5;
  localparam logic [3:0] KIND_PEAK_S = 4'd6;
  localparam logic [3:0] KIND_PEAK_T = 4'd7;
  localparam logic [3:0] KIND_PEAK_U = 4'd8;

  typedef struct packed {
    logic [3:0]          kind;
    logic [2:0]          wave;
    logic [SAMPLE_W-1:0] sample;
  } point_t;

  // one matched window plus which pattern hit
  typedef struct packed {
    logic                      pat_b;
    point_t [WIN_LEN-1:0]      pts;
  } snap_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic point_t map_code(input logic [5:0] code,
                                      input logic [SAMPLE_W-1:0] sample);
    point_t p;
    p.sample = sample;
    p.wave   = WAVE_UNK;
    p.kind   = KIND_UNK;
    unique case (code) inside
      6'd15, 6'd17: begin p.wave = WAVE_QRS; p.kind = KIND_PEAK_Q; end
      6'd24:        begin p.wave = WAVE_P;   p.kind = KIND_PEAK_P; end
      6'd27:        begin p.wave = WAVE_T;   p.kind = KIND_PEAK_T; end
      6'd29:        begin p.wave = WAVE_U;   p.kind = KIND_PEAK_U; end
      6'd1, 6'd39, 6'd46: begin p.wave = WAVE_QRS; p.kind = KIND_START; end
      6'd40:        begin p.wave = WAVE_QRS; p.kind = KIND_END;    end
      6'd42:        begin p.wave = WAVE_P;   p.kind = KIND_START;  end
      6'd43:        begin p.wave = WAVE_P;   p.kind = KIND_END;    end
      6'd44:        begin p.wave = WAVE_T;   p.kind = KIND_START;  end
      6'd45:        begin p.wave = WAVE_T;   p.kind = KIND_END;    end
      6'd47, 6'd48: begin p.wave = WAVE_QRS; p.kind = KIND_PEAK_R; end
      6'd49, 6'd50: begin p.wave = WAVE_QRS; p.kind = KIND_PEAK_S; end
      default:      begin p.wave = WAVE_UNK; p.kind = KIND_UNK;    end
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[design/ecgfc_front.sv]
// ecgfc_front: maps events, keeps the 11-point window and tests both patterns
// depends on ecgfc_pkg
`default_nettype none

module ecgfc_front import ecgfc_pkg::*; #(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic [5:0]          in_code,
  input  wire q_status_t           q_stat,
  output logic                     push,
  output snap_t                    push_data
);

  localparam int KEEP_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] KEEP_MASK =
    SAMPLE_W'((64'd1 << KEEP_BITS) - 64'd1);

  point_t              win [WIN_LEN];
  point_t              win_next [WIN_LEN];
  logic [FILL_W-1:0]   fill;
  logic [FILL_W-1:0]   fill_next;
  logic                accept;
  point_t              pt;
  logic                ppp;
  logic                pat_a;
  logic                pat_b;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign pt       = map_code(in_code, in_sample & KEEP_MASK);

  always_comb begin
    win_next  = win;
    fill_next = fill;
    if (accept) begin
      if (fill >= FILL_W'(WIN_LEN)) begin
        for (int i = 0; i < WIN_LEN - 1; i++) win_next[i] = win[i + 1];
        win_next[WIN_LEN-1] = pt;
      end else begin
        for (int i = 0; i < WIN_LEN; i++) begin
          if (fill == FILL_W'(i)) win_next[i] = pt;
        end
        fill_next = fill + FILL_W'(1);
      end
    end
  end

  // test the window as it stands after this item
  assign ppp   = win_next[0].wave == WAVE_P && win_next[1].wave == WAVE_P &&
                 win_next[2].wave == WAVE_P;
  assign pat_a = ppp && win_next[10].wave == WAVE_T;
  assign pat_b = ppp && win_next[7].wave == WAVE_T && win_next[8].wave == WAVE_T &&
                 win_next[9].wave == WAVE_T;

  assign push = accept && fill_next == FILL_W'(WIN_LEN) && (pat_a || pat_b);

  always_comb begin
    push_data.pat_b = !pat_a;
    for (int i = 0; i < WIN_LEN; i++) push_data.pts[i] = win_next[i];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_LEN; i++) win[i] <= win_next[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  a_push_full_window: assert property (@(posedge clk) disable iff (rst)
    push |-> fill_next == FILL_W'(WIN_LEN))
    else $error("match pushed before window filled");

endmodule

`default_nettype wire

[design/ecgfc_queue.sv]
// ecgfc_queue: short fifo of matched windows between front and back
// depends on ecgfc_pkg
`default_nettype none

module ecgfc_queue import ecgfc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire snap_t push_data,
  input  wire logic  pop,
  output snap_t      pop_data,
  output q_status_t  stat
);

  snap_t              entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign stat.full  = count == Q_CNT_W'(Q_DEPTH);
  assign stat.empty = count == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) count <= count + Q_CNT_W'(1);
      else if (do_pop && !do_push) count <= count - Q_CNT_W'(1);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && stat.full))
    else $error("push into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count overflow");

endmodule

`default_nettype wire

[design/ecgfc_back.sv]
// ecgfc_back: plays one matched window out as 13 framed points
// depends on ecgfc_pkg
`default_nettype none

module ecgfc_back import ecgfc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire q_status_t q_stat,
  input  wire snap_t     pop_data,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output point_t         out_pt,
  output logic           out_last
);

  snap_t              cur;
  logic               busy;
  logic [STEP_W-1:0]  step;
  logic               adv;
  logic [IDX_W-1:0]   idx;
  point_t             item;
  logic               item_last;

  assign pop = !busy && !q_stat.empty;
  assign adv = busy && (!out_valid || out_ready);

  always_comb begin
    idx = '0;
    if (cur.pat_b && step > STEP_W'(PEAKQ_STEP)) idx = IDX_W'(step - STEP_W'(2));
    else idx = IDX_W'(step - STEP_W'(1));
  end

  always_comb begin
    item      = cur.pts[idx];
    item_last = 1'b0;
    if (step == '0) begin
      item.sample = cur.pts[0].sample;
      item.wave   = WAVE_CYCLE;
      item.kind   = KIND_START;
    end else if (step == STEP_W'(STEP_LAST)) begin
      item.sample = cur.pts[WIN_LEN-1].sample;
      item.wave   = WAVE_CYCLE;
      item.kind   = KIND_END;
      item_last   = 1'b1;
    end else if (cur.pat_b && step == STEP_W'(PEAKQ_STEP)) begin
      // synthesized q peak at the fourth point
      item.sample = cur.pts[3].sample;
      item.wave   = WAVE_QRS;
      item.kind   = KIND_PEAK_Q;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= pop_data;
    if (adv) begin
      out_pt   <= item;
      out_last <= item_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        step <= '0;
      end else if (adv) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(STEP_LAST)) busy <= 1'b0;
      end
      if (adv) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_last_is_finish: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_pt.kind == KIND_END && out_pt.wave == WAVE_CYCLE)
    else $error("tlast on a point that is not a cycle finish");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> step <= STEP_W'(STEP_LAST))
    else $error("step counter past last item");

endmodule

`default_nettype wire

[design/ecg_fiducial_cycle_grouper.sv]
// ecg_fiducial_cycle_grouper: top level, front window, match queue and output sequencer
// depends on ecgfc_pkg, ecgfc_front, ecgfc_queue, ecgfc_back
`default_nettype none

// Groups detected ECG fiducial events into framed cardiac cycles. Each input
// item (sample position, annotator code) is mapped to a wave and point type and
// pushed into an 11-point sliding window; once the window is full it is tested
// at its oldest point, and a match (P,P,P ... T at offset 10, or P,P,P with T at
// offsets 7 to 9) produces 13 output items: a cycle start, the window points
// (for the second pattern only points 0 to 9, with a synthesized QRS peakQ
// after point 3) and a cycle finish that carries tlast. Input items are taken
// one per cycle as long as the two-entry match queue has room. Each match keeps
// the output sequencer busy for its 13 items, one per cycle when the sink is
// ready, and the next window loads once it is idle, so sustained throughput is
// set by that sequencer and the density of matches. No clearing pass is needed
// after reset; nothing is emitted before 11 events.
module ecg_fiducial_cycle_grouper import ecgfc_pkg::*; #(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // sample_index [31:0], peak_code [37:32], zero pad [39:38]
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // point_sample [31:0], wave_kind [34:32], point_kind [38:35], zero pad [39]
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tlast
);

  // front to queue
  logic      push;
  snap_t     push_data;
  // queue to back
  snap_t     pop_data;
  logic      pop;
  q_status_t q_stat;
  // output register contents
  point_t    out_pt;

  ecgfc_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_sample (s_axis_tdata[31:0]),
    .in_code   (s_axis_tdata[37:32]),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  ecgfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  ecgfc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_pt    (out_pt),
    .out_last  (m_axis_tlast)
  );

  // pack output fields lowest first
  assign m_axis_tdata = {1'b0, out_pt.kind, out_pt.wave, out_pt.sample};

endmodule

`default_nettype wire

[dv/ecgfc_tb_codes_pkg.sv]
// ecgfc_tb_codes_pkg: annotator event codes and random code pickers for the testbench
// no dependencies; used by the checker and the testbench top
package ecgfc_tb_codes_pkg;

  localparam logic [5:0] CODE_UNLISTED_LO = 6'd0;
  localparam logic [5:0] CODE_QRS_ON_A    = 6'd1;
  localparam logic [5:0] CODE_Q_PEAK_A    = 6'd15;
  localparam logic [5:0] CODE_Q_PEAK_B    = 6'd17;
  localparam logic [5:0] CODE_P_PEAK      = 6'd24;
  localparam logic [5:0] CODE_T_PEAK      = 6'd27;
  localparam logic [5:0] CODE_U_PEAK      = 6'd29;
  localparam logic [5:0] CODE_QRS_ON_B    = 6'd39;
  localparam logic [5:0] CODE_QRS_OFF     = 6'd40;
  localparam logic [5:0] CODE_P_ON        = 6'd42;
  localparam logic [5:0] CODE_P_OFF       = 6'd43;
  localparam logic [5:0] CODE_T_ON        = 6'd44;
  localparam logic [5:0] CODE_T_OFF       = 6'd45;
  localparam logic [5:0] CODE_QRS_ON_C    = 6'd46;
  localparam logic [5:0] CODE_R_PEAK_A    = 6'd47;
  localparam logic [5:0] CODE_R_PEAK_B    = 6'd48;
  localparam logic [5:0] CODE_S_PEAK_A    = 6'd49;
  localparam logic [5:0] CODE_S_PEAK_B    = 6'd50;
  localparam logic [5:0] CODE_UNLISTED_HI = 6'd63;

  function automatic logic [5:0] pick_p_code();
    case ($urandom_range(2))
      0: return CODE_P_PEAK;
      1: return CODE_P_ON;
      default: return CODE_P_OFF;
    endcase
  endfunction

  function automatic logic [5:0] pick_t_code();
    case ($urandom_range(2))
      0: return CODE_T_PEAK;
      1: return CODE_T_ON;
      default: return CODE_T_OFF;
    endcase
  endfunction

  // any code that maps to neither a p nor a t wave
  function automatic logic [5:0] pick_non_pt_code();
    logic [5:0] c;
    c = 6'($urandom_range(63));
    while (c == CODE_P_PEAK || c == CODE_P_ON || c == CODE_P_OFF ||
           c == CODE_T_PEAK || c == CODE_T_ON || c == CODE_T_OFF)
      c = 6'($urandom_range(63));
    return c;
  endfunction

endpackage

[dv/ecgfc_checker.sv]
// ecgfc_checker: watches both streams of the cycle grouper, predicts cycle frames, compares
// depends on ecgfc_pkg (point types, wave and point codes) and ecgfc_tb_codes_pkg
module ecgfc_checker import ecgfc_pkg::*; import ecgfc_tb_codes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          pending,
  output int          events_in,
  output int          points_out,
  output int          frames_plain,
  output int          frames_with_q
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic   last;
    point_t pt;
  } frame_point_t;

  point_t       fid_window [WIN_LEN];
  int           fid_fill;
  frame_point_t frame_points_due [$];
  int           n_fail, n_in, n_out, n_plain, n_q;

  function automatic point_t decode_event(input logic [5:0] code, input logic [31:0] sample);
    point_t p;
    p.sample = sample;
    p.wave   = WAVE_UNK;
    p.kind   = KIND_UNK;
    case (code)
      CODE_Q_PEAK_A, CODE_Q_PEAK_B: begin p.wave = WAVE_QRS; p.kind = KIND_PEAK_Q; end
      CODE_P_PEAK: begin p.wave = WAVE_P; p.kind = KIND_PEAK_P; end
      CODE_T_PEAK: begin p.wave = WAVE_T; p.kind = KIND_PEAK_T; end
      CODE_U_PEAK: begin p.wave = WAVE_U; p.kind = KIND_PEAK_U; end
      CODE_QRS_ON_A, CODE_QRS_ON_B, CODE_QRS_ON_C: begin
        p.wave = WAVE_QRS; p.kind = KIND_START;
      end
      CODE_QRS_OFF: begin p.wave = WAVE_QRS; p.kind = KIND_END; end
      CODE_P_ON: begin p.wave = WAVE_P; p.kind = KIND_START; end
      CODE_P_OFF: begin p.wave = WAVE_P; p.kind = KIND_END; end
      CODE_T_ON: begin p.wave = WAVE_T; p.kind = KIND_START; end
      CODE_T_OFF: begin p.wave = WAVE_T; p.kind = KIND_END; end
      CODE_R_PEAK_A, CODE_R_PEAK_B: begin p.wave = WAVE_QRS; p.kind = KIND_PEAK_R; end
      CODE_S_PEAK_A, CODE_S_PEAK_B: begin p.wave = WAVE_QRS; p.kind = KIND_PEAK_S; end
      default: begin p.wave = WAVE_UNK; p.kind = KIND_UNK; end
    endcase
    return p;
  endfunction

  task automatic queue_point(input logic [31:0] sample, input logic [2:0] wave,
                             input logic [3:0] kind, input logic last);
    frame_point_t fp;
    fp.pt.sample = sample;
    fp.pt.wave   = wave;
    fp.pt.kind   = kind;
    fp.last      = last;
    frame_points_due = {frame_points_due, fp};
  endtask

  // slide the event into the window, then test the full window at its oldest point
  task automatic absorb_event(input point_t pt);
    logic three_p, hit_a, hit_b;
    if (fid_fill == WIN_LEN) begin
      for (int i = 0; i < WIN_LEN - 1; i++) fid_window[i] = fid_window[i+1];
      fid_window[WIN_LEN-1] = pt;
    end else begin
      fid_window[fid_fill] = pt;
      fid_fill++;
    end
    if (fid_fill == WIN_LEN) begin
      three_p = fid_window[0].wave == WAVE_P && fid_window[1].wave == WAVE_P &&
                fid_window[2].wave == WAVE_P;
      hit_a = three_p && fid_window[10].wave == WAVE_T;
      hit_b = three_p && fid_window[7].wave == WAVE_T && fid_window[8].wave == WAVE_T &&
              fid_window[9].wave == WAVE_T;
      if (hit_a || hit_b) begin
        queue_point(fid_window[0].sample, WAVE_CYCLE, KIND_START, 1'b0);
        for (int i = 0; i < 10; i++) begin
          queue_point(fid_window[i].sample, fid_window[i].wave, fid_window[i].kind, 1'b0);
          // the t-tail pattern gets a peak q made up at point 3
          if (!hit_a && i == 3) queue_point(fid_window[3].sample, WAVE_QRS, KIND_PEAK_Q, 1'b0);
        end
        if (hit_a) begin
          queue_point(fid_window[10].sample, fid_window[10].wave, fid_window[10].kind, 1'b0);
          n_plain++;
        end else begin
          n_q++;
        end
        queue_point(fid_window[10].sample, WAVE_CYCLE, KIND_END, 1'b1);
      end
    end
  endtask

  always @(posedge clk) begin
    frame_point_t due;
    if (rst) begin
      fid_fill = 0;
      frame_points_due.delete();
      n_fail = 0; n_in = 0; n_out = 0; n_plain = 0; n_q = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        n_in++;
        absorb_event(decode_event(s_axis_tdata[37:32], s_axis_tdata[31:0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_out++;
        if (frame_points_due.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: unexpected output item sample %h wave %0d kind %0d last %0b",
                     $realtime, m_axis_tdata[31:0], m_axis_tdata[34:32],
                     m_axis_tdata[38:35], m_axis_tlast);
        end else begin
          due = frame_points_due.pop_front();
          if (m_axis_tdata[31:0] !== due.pt.sample || m_axis_tdata[34:32] !== due.pt.wave ||
              m_axis_tdata[38:35] !== due.pt.kind || m_axis_tlast !== due.last ||
              m_axis_tdata[39] !== 1'b0) begin
            n_fail++;
            if (n_fail <= 10)
              $display("%0t: output item %0d: expected sample %h wave %0d kind %0d last %0b, got sample %h wave %0d kind %0d last %0b pad %b",
                       $realtime, n_out, due.pt.sample, due.pt.wave, due.pt.kind, due.last,
                       m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tdata[38:35],
                       m_axis_tlast, m_axis_tdata[39]);
          end
        end
      end
    end
    fail_count    <= n_fail;
    pending       <= frame_points_due.size();
    events_in     <= n_in;
    points_out    <= n_out;
    frames_plain  <= n_plain;
    frames_with_q <= n_q;
  end

endmodule

[dv/tb_ecg_fiducial_cycle_grouper.sv]
// tb_ecg_fiducial_cycle_grouper: stimulus, sink back-pressure and verdict for the cycle grouper
// depends on ecgfc_pkg, ecgfc_tb_codes_pkg, ecgfc_checker and the design under test
module tb_ecg_fiducial_cycle_grouper import ecgfc_tb_codes_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EVENT_TARGET = 310;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // sample_index [31:0], peak_code [37:32], pad [39:38]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // point_sample [31:0], wave_kind [34:32], point_kind [38:35]
  logic        m_axis_tlast;

  int fail_count, pending, events_in, points_out, frames_plain, frames_with_q;
  int events_sent;
  int send_idle_pct = 0;   // chance in a hundred that the source holds off, redrawn while it holds off
  int sink_stall_pct = 0;  // chance in a hundred that the sink drops tready

  // 20 ns clock
  always #10 clk = ~clk;

  ecg_fiducial_cycle_grouper dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  ecgfc_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .pending       (pending),
    .events_in     (events_in),
    .points_out    (points_out),
    .frames_plain  (frames_plain),
    .frames_with_q (frames_with_q)
  );

  // sink back-pressure, redrawn every cycle
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // samples lean toward the extremes now and then
  function automatic logic [31:0] pick_sample();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // one fiducial event; called at a rising edge, returns at the edge that took it
  task automatic send_event(input logic [31:0] sample, input logic [5:0] code);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, code, sample};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    events_sent++;
  endtask

  // a run of events shaped like a beat, or a bit of noise
  task automatic send_random_run();
    int shape;
    int n;
    shape = $urandom_range(9);
    if (shape < 7) begin
      // p, p, p opening; the tail picks the plain or the t-tail pattern
      for (int i = 0; i < 3; i++) send_event(pick_sample(), pick_p_code());
      if (shape < 3) begin
        for (int i = 3; i < 10; i++) send_event(pick_sample(), 6'($urandom_range(63)));
        send_event(pick_sample(), pick_t_code());
      end else begin
        for (int i = 3; i < 7; i++) send_event(pick_sample(), 6'($urandom_range(63)));
        for (int i = 7; i < 10; i++) send_event(pick_sample(), pick_t_code());
        // a t at the end too means both patterns hold, plain one wins
        if (shape == 6) send_event(pick_sample(), pick_t_code());
        else send_event(pick_sample(), pick_non_pt_code());
      end
    end else if (shape < 9) begin
      // broken beat: opening p run cut short
      n = $urandom_range(1, 2);
      for (int i = 0; i < n; i++) send_event(pick_sample(), pick_p_code());
      n = $urandom_range(2, 9);
      for (int i = 0; i < n; i++) send_event(pick_sample(), 6'($urandom_range(63)));
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) send_event(pick_sample(), 6'($urandom_range(63)));
    end
  endtask

  initial begin
    events_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: first ten events fill the window with nothing out, the eleventh closes
    // a plain p,p,p..t beat with q peak, qrs on, qrs off and r peak codes in between
    send_event(32'h0000_0000, CODE_P_PEAK);
    send_event(pick_sample(), CODE_P_ON);
    send_event(pick_sample(), CODE_P_OFF);
    send_event(pick_sample(), CODE_Q_PEAK_A);
    send_event(pick_sample(), CODE_Q_PEAK_B);
    send_event(pick_sample(), CODE_QRS_ON_A);
    send_event(pick_sample(), CODE_QRS_ON_B);
    send_event(pick_sample(), CODE_QRS_ON_C);
    send_event(pick_sample(), CODE_QRS_OFF);
    send_event(pick_sample(), CODE_R_PEAK_A);
    send_event(32'hFFFF_FFFF, CODE_T_PEAK);
    // windows in between fail; the last one is the t-tail beat with an unlisted finish
    send_event(32'hFFFF_FFFF, CODE_P_ON);
    send_event(pick_sample(), CODE_P_PEAK);
    send_event(pick_sample(), CODE_P_OFF);
    send_event(32'h8000_0001, CODE_R_PEAK_B);
    send_event(pick_sample(), CODE_S_PEAK_A);
    send_event(pick_sample(), CODE_S_PEAK_B);
    send_event(pick_sample(), CODE_U_PEAK);
    send_event(pick_sample(), CODE_T_ON);
    send_event(pick_sample(), CODE_T_PEAK);
    send_event(pick_sample(), CODE_T_OFF);
    send_event(32'h0000_0000, CODE_UNLISTED_LO);
    // no-match windows with unlisted codes
    send_event(pick_sample(), CODE_UNLISTED_HI);
    send_event(pick_sample(), 6'd2);
    send_event(pick_sample(), 6'd51);

    // random part in four idling phases
    while (events_sent < EVENT_TARGET) begin
      case (events_sent * 4 / EVENT_TARGET)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 51; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 51; end
        default: begin send_idle_pct = 8; sink_stall_pct = 8; end
      endcase
      send_random_run();
    end
    s_axis_tvalid <= 1'b0;

    // let the checker count the last event, drain, then leave room for any stray output
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d fiducial events, %0d cycle frames (%0d plain, %0d with peak q added)",
             events_in, frames_plain + frames_with_q, frames_plain, frames_with_q);
    $display("checked %0d output points, %0d mismatches", points_out, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[sim.f]
design/ecgfc_pkg.sv
design/ecgfc_front.sv
design/ecgfc_queue.sv
design/ecgfc_back.sv
design/ecg_fiducial_cycle_grouper.sv
dv/ecgfc_tb_codes_pkg.sv
dv/ecgfc_checker.sv
dv/tb_ecg_fiducial_cycle_grouper.sv
